// ----- rtl/core/sfbp_pkg.sv -----
package sfbp_pkg;

  localparam int LINES_PER_FRAME = 24;
  localparam int BYTES_PER_LINE  = 65;
  localparam int STATUS_BYTES    = 2;
  localparam int TRAILER_BYTES   = 4;
  localparam int ECHO_LEN        = 10;

  localparam int SECTION_W = 7;
  localparam int LINE_W    = 5;
  localparam int COUNT_W   = 11;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_C    = 8'h43;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ECHO    = 3'd1,
    PH_STATUS  = 3'd2,
    PH_DATA    = 3'd3,
    PH_TRAILER = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SEND  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          second_char;
    logic [7:0]          first_char;
    logic                valid_flag;
    logic [COUNT_W-1:0]  pair_count;
  } result_t;

  // expected echo text before the line ending
  function automatic logic [7:0] echo_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h47;
      4'd1:    c = 8'h30;
      4'd2:    c = 8'h30;
      4'd3:    c = 8'h30;
      4'd4:    c = 8'h37;
      4'd5:    c = 8'h36;
      4'd6:    c = 8'h38;
      4'd7:    c = 8'h30;
      4'd8:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/sfbp_parser.sv -----
module sfbp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  command_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output sfbp_pkg::result_t     res_o
);

  sfbp_pkg::phase_e                   phase_q, phase_d;
  logic [sfbp_pkg::SECTION_W-1:0]     bis_q, bis_d, bis_inc;
  logic [sfbp_pkg::LINE_W-1:0]        line_q, line_d, line_inc;
  logic                               echo_ok_q, echo_ok_d;
  logic [7:0]                         first_q, first_d;
  logic [7:0]                         second_q, second_d;
  logic [sfbp_pkg::COUNT_W-1:0]       pairs_q, pairs_d;
  logic                               echo_match;
  logic                               busy;
  logic                               is_byte;

  assign is_byte  = (command_i == sfbp_pkg::CMD_BYTE);
  assign bis_inc  = bis_q + 1'b1;
  assign line_inc = line_q + 1'b1;
  assign busy     = (phase_q == sfbp_pkg::PH_ECHO) || (phase_q == sfbp_pkg::PH_STATUS) ||
                    (phase_q == sfbp_pkg::PH_DATA) || (phase_q == sfbp_pkg::PH_TRAILER);

  always_comb begin
    if (bis_q < sfbp_pkg::SECTION_W'(9)) begin
      echo_match = (rx_byte_i == sfbp_pkg::echo_char(bis_q[3:0]));
    end else begin
      echo_match = (rx_byte_i == sfbp_pkg::CHAR_LF) || (rx_byte_i == sfbp_pkg::CHAR_CR);
    end
  end

  // next state
  always_comb begin
    phase_d   = phase_q;
    bis_d     = bis_q;
    line_d    = line_q;
    echo_ok_d = echo_ok_q;
    first_d   = first_q;
    second_d  = second_q;
    pairs_d   = pairs_q;
    if (!is_byte) begin
      if (!busy) begin
        phase_d   = sfbp_pkg::PH_ECHO;
        bis_d     = '0;
        echo_ok_d = 1'b1;
      end
    end else begin
      case (phase_q)
        sfbp_pkg::PH_ECHO: begin
          echo_ok_d = echo_ok_q & echo_match;
          bis_d     = bis_inc;
          if (bis_inc >= sfbp_pkg::SECTION_W'(sfbp_pkg::ECHO_LEN)) begin
            bis_d = '0;
            if (!echo_ok_d) begin
              phase_d = sfbp_pkg::PH_IDLE;
            end else if (sfbp_pkg::STATUS_BYTES > 0) begin
              phase_d = sfbp_pkg::PH_STATUS;
            end else begin
              phase_d = sfbp_pkg::PH_DATA;
              line_d  = '0;
              pairs_d = '0;
            end
          end
        end
        sfbp_pkg::PH_STATUS: begin
          bis_d = bis_inc;
          if (bis_inc >= sfbp_pkg::SECTION_W'(sfbp_pkg::STATUS_BYTES)) begin
            bis_d   = '0;
            phase_d = sfbp_pkg::PH_DATA;
            line_d  = '0;
            pairs_d = '0;
          end
        end
        sfbp_pkg::PH_DATA: begin
          if (!bis_q[0]) begin
            first_d = rx_byte_i;
          end else begin
            second_d = rx_byte_i;
            pairs_d  = pairs_q + 1'b1;
          end
          bis_d = bis_inc;
          if (bis_inc >= sfbp_pkg::SECTION_W'(sfbp_pkg::BYTES_PER_LINE)) begin
            bis_d  = '0;
            line_d = line_inc;
            if (line_inc >= sfbp_pkg::LINE_W'(sfbp_pkg::LINES_PER_FRAME)) begin
              line_d  = '0;
              phase_d = (sfbp_pkg::TRAILER_BYTES > 0) ? sfbp_pkg::PH_TRAILER
                                                      : sfbp_pkg::PH_IDLE;
            end
          end
        end
        sfbp_pkg::PH_TRAILER: begin
          bis_d = bis_inc;
          if (bis_inc >= sfbp_pkg::SECTION_W'(sfbp_pkg::TRAILER_BYTES)) begin
            bis_d   = '0;
            phase_d = sfbp_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = sfbp_pkg::KIND_SEND;
    if (!is_byte) begin
      res_valid_o = !busy;
    end else begin
      case (phase_q)
        sfbp_pkg::PH_ECHO: begin
          if ((bis_inc >= sfbp_pkg::SECTION_W'(sfbp_pkg::ECHO_LEN)) && !echo_ok_d) begin
            res_valid_o = 1'b1;
            res_o.kind  = sfbp_pkg::KIND_ABORT;
          end
        end
        sfbp_pkg::PH_DATA: begin
          res_valid_o       = 1'b1;
          res_o.kind        = sfbp_pkg::KIND_DATA;
          res_o.second_char = second_d;
          res_o.first_char  = first_d;
          res_o.valid_flag  = bis_q[0] &&
                              !((first_q == sfbp_pkg::CHAR_ZERO) &&
                                (rx_byte_i <= sfbp_pkg::CHAR_C));
          res_o.pair_count  = pairs_d;
        end
        default: begin
        end
      endcase
    end
    res_valid_o = res_valid_o & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sfbp_pkg::PH_IDLE;
      bis_q     <= '0;
      line_q    <= '0;
      echo_ok_q <= 1'b1;
      first_q   <= '0;
      second_q  <= '0;
      pairs_q   <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      bis_q     <= bis_d;
      line_q    <= line_d;
      echo_ok_q <= echo_ok_d;
      first_q   <= first_d;
      second_q  <= second_d;
      pairs_q   <= pairs_d;
    end
  end

endmodule

// ----- rtl/core/sfbp_out_buf.sv -----
module sfbp_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfbp_pkg::result_t  push_data_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sfbp_pkg::result_t  out_data_o
);

  logic               main_valid_q, main_valid_d;
  logic               skid_valid_q, skid_valid_d;
  sfbp_pkg::result_t  main_q, main_d;
  sfbp_pkg::result_t  skid_q, skid_d;
  logic               pop;

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;
  assign pop         = main_valid_q & out_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ----- rtl/core/sensor_frame_byte_parser.sv -----
// a result is registered into the output buffer when its request is accepted
// throughput: one request per cycle while the output buffer is ready
// a two-entry output buffer keeps input ready while one result waits to be taken
// reset: asynchronous active low; parser idle, counters and character slots zero,
// echo status set, output buffer empty
module sensor_frame_byte_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    second_char_o,
  output logic [7:0]                    first_char_o,
  output logic                          valid_flag_o,
  output logic [sfbp_pkg::COUNT_W-1:0]  pair_count_o
);

  logic               accept;
  logic               res_valid;
  logic               buf_ready;
  sfbp_pkg::result_t  res;
  sfbp_pkg::result_t  out_data;

  assign in_ready_o = buf_ready;
  assign accept     = in_valid_i & buf_ready;

  sfbp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfbp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o        = out_data.kind;
  assign second_char_o = out_data.second_char;
  assign first_char_o  = out_data.first_char;
  assign valid_flag_o  = out_data.valid_flag;
  assign pair_count_o  = out_data.pair_count;

endmodule
